// ----- hw/rtl/tcch_pkg.sv -----
`timescale 1ns / 1ps
// tcch_pkg: types, constants and tables for the tilt-compensated compass heading block
// no dependencies; imported by the top level and its checker

package tcch_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_LEN = 24;
  localparam int N_ITER = (CORDIC_ITERATIONS > ATAN_LEN) ? ATAN_LEN : CORDIC_ITERATIONS;
  localparam int LATENCY = 2 * N_ITER + 13;
  localparam int MILLI_DLY = LATENCY - 6;

  localparam int ADDR_W = 4;
  localparam int OFS_W = 18;
  localparam int NUM_AXES = 3;
  localparam int NUM_ANG = 2;

  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;
  localparam int LANE_ROLL = 0;
  localparam int LANE_PITCH = 1;

  // datapath widths
  localparam int MAG_W = 24;
  localparam int ROT_W = 33;
  localparam int TV_W = 27;
  localparam int P1_W = MAG_W + ROT_W;
  localparam int P2_W = TV_W + ROT_W;
  localparam int HV_W = 28;
  localparam int VEC_W = 30;
  localparam int VZ_W = 35;
  localparam int U_W = 34;
  localparam int MP_W = 34;

  typedef enum logic [1:0] {
    REG_OFFSET_X = 2'd0,
    REG_OFFSET_Y = 2'd1,
    REG_OFFSET_Z = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] raw_first;
    logic signed [15:0] raw_second;
    logic signed [15:0] raw_third;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
  } tcch_in_t;

  typedef struct packed {
    logic signed [11:0] heading_tenths;
    logic signed [15:0] field_x_milli;
    logic signed [15:0] field_y_milli;
    logic signed [15:0] field_z_milli;
  } tcch_out_t;

  // counts to Q16 gauss: floor(n * 65536 / 1090) by reciprocal, then one correction
  localparam logic [31:0] MAG_RECIP = 32'd4034905056;
  localparam int MAG_RECIP_SHIFT = 26;
  localparam logic [31:0] MAG_GAIN = 32'd1090;
  localparam logic [2:0] MAG_NEGATE = 3'b101;
  localparam logic signed [MAG_W-1:0] MAG_BIAS [NUM_AXES] = '{
    24'sd7209, 24'sd2294, -24'sd3932
  };

  // Q16 gauss to milligauss
  localparam logic signed [MP_W-1:0] MILLI_SCALE = 34'sd1000;
  localparam logic signed [MP_W-1:0] MILLI_RND = 34'sd65535;
  localparam logic signed [MP_W-1:0] MILLI_MAX = 34'sd32767;
  localparam logic signed [MP_W-1:0] MILLI_MIN = -34'sd32768;

  // angle reduction, hundredths of a degree
  localparam logic signed [16:0] FULL_TURN = 17'sd36000;
  localparam logic signed [16:0] HALF_TURN = 17'sd18000;
  localparam logic signed [16:0] QUARTER_TURN = 17'sd9000;

  // a * pi / 18000 = a * ANG_A + floor(a * ANG_B / 18000)
  localparam logic [30:0] ANG_A = 31'd187403;
  localparam logic [25:0] ANG_B = 26'd5426;
  localparam logic [51:0] ANG_RECIP = 52'd61083979;
  localparam int ANG_RECIP_SHIFT = 40;
  localparam logic [25:0] ANG_DEN = 26'd18000;

  localparam logic signed [ROT_W-1:0] ROT_GAIN = 33'sd652032874;
  localparam logic signed [VZ_W-1:0] PI_Q30 = 35'sd3373259426;

  // z * 1800 / pi by reciprocal and one correction
  localparam logic [45:0] HEAD_RECIP = 46'd2291;
  localparam logic [44:0] HEAD_SCALE = 45'd1800;
  localparam logic [45:0] PI_MAG = 46'd3373259426;
  localparam logic [13:0] HEAD_MAX = 14'd1800;

  localparam logic [29:0] ATAN_TAB [ATAN_LEN] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535,
    30'd32767, 30'd16383, 30'd8191, 30'd4095, 30'd2047,
    30'd1023, 30'd511, 30'd255, 30'd127
  };

endpackage

// ----- hw/rtl/tilt_compensated_compass_heading_top.sv -----
`timescale 1ns / 1ps
// tilt_compensated_compass_heading_top: pipelined magnetometer calibration, tilt
// compensation and heading; depends on tcch_pkg

// One request enters per clock and busy stays low: every request accepted with start
// gives exactly one result on rsp, marked by done, in request order. Most of the
// pipeline is the two CORDIC pipelines, one stage per iteration, for sine/cosine of
// roll and pitch and for the final atan2. Results cannot be held off; the receiver
// must take done when it comes. Offsets must be written over the APB port only while
// no request is in flight; the block itself does not enforce it.

module tilt_compensated_compass_heading_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  tcch_pkg::tcch_in_t          req,
  output logic                        done,
  output tcch_pkg::tcch_out_t         rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcch_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tcch_pkg::*;

  logic [LATENCY-1:0] vld;
  logic signed [OFS_W-1:0] ofs [NUM_AXES];

  // magnitude path
  logic signed [15:0] raw [NUM_AXES];
  logic [15:0] raw_abs [NUM_AXES];
  logic [15:0] mg1_abs [NUM_AXES], mg2_abs [NUM_AXES], mg3_abs [NUM_AXES];
  logic mg1_neg [NUM_AXES], mg2_neg [NUM_AXES], mg3_neg [NUM_AXES], mg4_neg [NUM_AXES];
  logic [47:0] mg1_prod [NUM_AXES];
  logic [21:0] mg2_q0 [NUM_AXES], mg3_q0 [NUM_AXES], mg4_q [NUM_AXES];
  logic [31:0] mg3_qm [NUM_AXES];
  logic [31:0] mg4_rem [NUM_AXES];
  logic signed [MAG_W-1:0] mag_val [NUM_AXES];
  logic signed [MAG_W-1:0] mdl [NUM_AXES][N_ITER+2];
  logic signed [MP_W-1:0] ml6_p [NUM_AXES];
  logic signed [MP_W-1:0] ml_adj [NUM_AXES], ml_div [NUM_AXES];
  logic signed [15:0] ml_sat [NUM_AXES];
  logic signed [15:0] mil [NUM_AXES][MILLI_DLY];

  // angle path
  logic signed [16:0] ang_in [NUM_ANG], ang_wrap [NUM_ANG], ang_fold [NUM_ANG];
  logic ang_flip [NUM_ANG];
  logic [13:0] an1_abs [NUM_ANG];
  logic an1_sgn [NUM_ANG], an2_sgn [NUM_ANG], an3_sgn [NUM_ANG], an4_sgn [NUM_ANG];
  logic an1_flip [NUM_ANG], an2_flip [NUM_ANG], an3_flip [NUM_ANG], an4_flip [NUM_ANG];
  logic [30:0] an2_pa [NUM_ANG], an3_pa [NUM_ANG], an4_pa [NUM_ANG];
  logic [25:0] an2_pb [NUM_ANG], an3_pb [NUM_ANG], an4_pb [NUM_ANG];
  logic [51:0] an3_pe [NUM_ANG];
  logic [11:0] an4_qe [NUM_ANG];
  logic [25:0] an4_qm [NUM_ANG];
  logic [25:0] an_rem [NUM_ANG];
  logic [11:0] an_q2 [NUM_ANG];
  logic [30:0] an_zmag [NUM_ANG];
  logic signed [ROT_W-1:0] an_z [NUM_ANG];
  logic signed [ROT_W-1:0] rot_x [NUM_ANG][N_ITER+1];
  logic signed [ROT_W-1:0] rot_y [NUM_ANG][N_ITER+1];
  logic signed [ROT_W-1:0] rot_z [NUM_ANG][N_ITER+1];
  logic rot_neg [NUM_ANG][N_ITER+1];
  logic signed [ROT_W-1:0] sc_sin [NUM_ANG], sc_cos [NUM_ANG];

  // tilt compensation
  logic signed [P1_W-1:0] p_a, p_b, p_c, p_d, p_e;
  logic signed [P2_W-1:0] p_bs, p_cs;
  logic signed [TV_W-1:0] t1_a, t1_b, t1_c, t1_d, t1_e;
  logic signed [ROT_W-1:0] t1_sp;
  logic signed [TV_W-1:0] t2_a, t2_b, t2_c, t2_d, t2_e;
  logic signed [HV_W-1:0] t3_hx, t3_hy;

  // atan2 and heading
  logic signed [VEC_W-1:0] vi_x, vi_y;
  logic signed [VZ_W-1:0] vi_z;
  logic signed [VEC_W-1:0] vx [N_ITER+1], vy [N_ITER+1];
  logic signed [VZ_W-1:0] vz [N_ITER+1];
  logic vzero [N_ITER+1];
  logic [U_W-1:0] hu;
  logic [U_W-1:0] h1_u;
  logic [45:0] h1_prod;
  logic h1_sgn, h1_zero, h2_sgn, h2_zero;
  logic [13:0] h2_qe;
  logic [44:0] h2_un;
  logic [45:0] h2_qp;
  logic [46:0] h_rem;
  logic [13:0] h_q, h_qs;
  logic signed [11:0] h3_head;

  assign busy = 1'b0;
  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        ofs[k] <= '0;
      end
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_OFFSET_X: ofs[AXIS_X] <= OFS_W'(pwdata);
        REG_OFFSET_Y: ofs[AXIS_Y] <= OFS_W'(pwdata);
        REG_OFFSET_Z: ofs[AXIS_Z] <= OFS_W'(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_OFFSET_X: prdata = 32'(ofs[AXIS_X]);
      REG_OFFSET_Y: prdata = 32'(ofs[AXIS_Y]);
      REG_OFFSET_Z: prdata = 32'(ofs[AXIS_Z]);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start && !busy};
    end
  end

  // counts to Q16 gauss
  assign raw[AXIS_X] = $signed(req.raw_first);
  assign raw[AXIS_Y] = $signed(req.raw_third);
  assign raw[AXIS_Z] = $signed(req.raw_second);

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      raw_abs[k] = raw[k][15] ? 16'(-raw[k]) : 16'(raw[k]);
      mg4_rem[k] = {mg3_abs[k], 16'h0000} - mg3_qm[k];
      mag_val[k] = (mg4_neg[k] ? -MAG_W'(mg4_q[k]) : MAG_W'(mg4_q[k]))
                   + MAG_BIAS[k] - MAG_W'(ofs[k]);
      ml_adj[k] = ml6_p[k] + (ml6_p[k][MP_W-1] ? MILLI_RND : '0);
      ml_div[k] = ml_adj[k] >>> 16;
      if (ml_div[k] > MILLI_MAX) begin
        ml_sat[k] = 16'(MILLI_MAX);
      end else if (ml_div[k] < MILLI_MIN) begin
        ml_sat[k] = 16'(MILLI_MIN);
      end else begin
        ml_sat[k] = 16'(ml_div[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_AXES; k++) begin
      mg1_abs[k] <= raw_abs[k];
      mg1_neg[k] <= raw[k][15];
      mg1_prod[k] <= 48'(raw_abs[k]) * 48'(MAG_RECIP);
      mg2_abs[k] <= mg1_abs[k];
      mg2_neg[k] <= mg1_neg[k];
      mg2_q0[k] <= mg1_prod[k][47:MAG_RECIP_SHIFT];
      mg3_abs[k] <= mg2_abs[k];
      mg3_neg[k] <= mg2_neg[k];
      mg3_q0[k] <= mg2_q0[k];
      mg3_qm[k] <= 32'(mg2_q0[k]) * MAG_GAIN;
      mg4_q[k] <= (mg4_rem[k] >= MAG_GAIN) ? mg3_q0[k] + 22'd1 : mg3_q0[k];
      mg4_neg[k] <= mg3_neg[k] ^ MAG_NEGATE[k];
      mdl[k][0] <= mag_val[k];
      for (int j = 1; j < N_ITER + 2; j++) begin
        mdl[k][j] <= mdl[k][j-1];
      end
      ml6_p[k] <= MP_W'(mdl[k][0]) * MILLI_SCALE;
      mil[k][0] <= ml_sat[k];
      for (int j = 1; j < MILLI_DLY; j++) begin
        mil[k][j] <= mil[k][j-1];
      end
    end
  end

  // angles to Q30 radians
  assign ang_in[LANE_ROLL] = 17'($signed(req.roll_angle));
  assign ang_in[LANE_PITCH] = 17'($signed(req.pitch_angle));

  always_comb begin
    for (int l = 0; l < NUM_ANG; l++) begin
      if (ang_in[l] > HALF_TURN) begin
        ang_wrap[l] = ang_in[l] - FULL_TURN;
      end else if (ang_in[l] < -HALF_TURN) begin
        ang_wrap[l] = ang_in[l] + FULL_TURN;
      end else begin
        ang_wrap[l] = ang_in[l];
      end
      ang_flip[l] = 1'b0;
      ang_fold[l] = ang_wrap[l];
      if (ang_wrap[l] > QUARTER_TURN) begin
        ang_fold[l] = ang_wrap[l] - HALF_TURN;
        ang_flip[l] = 1'b1;
      end else if (ang_wrap[l] < -QUARTER_TURN) begin
        ang_fold[l] = ang_wrap[l] + HALF_TURN;
        ang_flip[l] = 1'b1;
      end
      an_rem[l] = an4_pb[l] - an4_qm[l];
      an_q2[l] = (an_rem[l] >= ANG_DEN) ? an4_qe[l] + 12'd1 : an4_qe[l];
      an_zmag[l] = an4_pa[l] + 31'(an_q2[l]);
      an_z[l] = an4_sgn[l] ? -ROT_W'(an_zmag[l]) : ROT_W'(an_zmag[l]);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < NUM_ANG; l++) begin
      an1_abs[l] <= 14'(ang_fold[l][16] ? -ang_fold[l] : ang_fold[l]);
      an1_sgn[l] <= ang_fold[l][16];
      an1_flip[l] <= ang_flip[l];
      an2_pa[l] <= 31'(an1_abs[l]) * ANG_A;
      an2_pb[l] <= 26'(an1_abs[l]) * ANG_B;
      an2_sgn[l] <= an1_sgn[l];
      an2_flip[l] <= an1_flip[l];
      an3_pe[l] <= 52'(an2_pb[l]) * ANG_RECIP;
      an3_pa[l] <= an2_pa[l];
      an3_pb[l] <= an2_pb[l];
      an3_sgn[l] <= an2_sgn[l];
      an3_flip[l] <= an2_flip[l];
      an4_qe[l] <= an3_pe[l][51:ANG_RECIP_SHIFT];
      an4_qm[l] <= 26'(an3_pe[l][51:ANG_RECIP_SHIFT]) * ANG_DEN;
      an4_pa[l] <= an3_pa[l];
      an4_pb[l] <= an3_pb[l];
      an4_sgn[l] <= an3_sgn[l];
      an4_flip[l] <= an3_flip[l];
    end
  end

  // rotation cordic, one iteration per stage
  always_ff @(posedge clk) begin
    for (int l = 0; l < NUM_ANG; l++) begin
      rot_x[l][0] <= ROT_GAIN;
      rot_y[l][0] <= '0;
      rot_z[l][0] <= an_z[l];
      rot_neg[l][0] <= an4_flip[l];
      for (int i = 0; i < N_ITER; i++) begin
        rot_neg[l][i+1] <= rot_neg[l][i];
        if (!rot_z[l][i][ROT_W-1]) begin
          rot_x[l][i+1] <= rot_x[l][i] - (rot_y[l][i] >>> i);
          rot_y[l][i+1] <= rot_y[l][i] + (rot_x[l][i] >>> i);
          rot_z[l][i+1] <= rot_z[l][i] - $signed(ROT_W'(ATAN_TAB[i]));
        end else begin
          rot_x[l][i+1] <= rot_x[l][i] + (rot_y[l][i] >>> i);
          rot_y[l][i+1] <= rot_y[l][i] - (rot_x[l][i] >>> i);
          rot_z[l][i+1] <= rot_z[l][i] + $signed(ROT_W'(ATAN_TAB[i]));
        end
      end
      sc_sin[l] <= rot_neg[l][N_ITER] ? -rot_y[l][N_ITER] : rot_y[l][N_ITER];
      sc_cos[l] <= rot_neg[l][N_ITER] ? -rot_x[l][N_ITER] : rot_x[l][N_ITER];
    end
  end

  // tilt compensation
  always_comb begin
    p_a = P1_W'(mdl[AXIS_X][N_ITER+1]) * P1_W'(sc_cos[LANE_PITCH]);
    p_b = P1_W'(mdl[AXIS_Y][N_ITER+1]) * P1_W'(sc_sin[LANE_ROLL]);
    p_c = P1_W'(mdl[AXIS_Z][N_ITER+1]) * P1_W'(sc_cos[LANE_ROLL]);
    p_d = P1_W'(mdl[AXIS_Y][N_ITER+1]) * P1_W'(sc_cos[LANE_ROLL]);
    p_e = P1_W'(mdl[AXIS_Z][N_ITER+1]) * P1_W'(sc_sin[LANE_ROLL]);
    p_bs = P2_W'(t1_b) * P2_W'(t1_sp);
    p_cs = P2_W'(t1_c) * P2_W'(t1_sp);
  end

  always_ff @(posedge clk) begin
    t1_a <= TV_W'(p_a >>> 30);
    t1_b <= TV_W'(p_b >>> 30);
    t1_c <= TV_W'(p_c >>> 30);
    t1_d <= TV_W'(p_d >>> 30);
    t1_e <= TV_W'(p_e >>> 30);
    t1_sp <= sc_sin[LANE_PITCH];
    t2_a <= t1_a;
    t2_b <= TV_W'(p_bs >>> 30);
    t2_c <= TV_W'(p_cs >>> 30);
    t2_d <= t1_d;
    t2_e <= t1_e;
    t3_hx <= HV_W'(t2_a) + HV_W'(t2_b) + HV_W'(t2_c);
    t3_hy <= HV_W'(t2_d) - HV_W'(t2_e);
  end

  // atan2(-hy, hx), left half plane rotated by pi first
  always_comb begin
    if (t3_hx[HV_W-1]) begin
      vi_x = -VEC_W'(t3_hx);
      vi_y = VEC_W'(t3_hy);
      vi_z = (t3_hy <= 0) ? PI_Q30 : -PI_Q30;
    end else begin
      vi_x = VEC_W'(t3_hx);
      vi_y = -VEC_W'(t3_hy);
      vi_z = '0;
    end
  end

  always_ff @(posedge clk) begin
    vx[0] <= vi_x;
    vy[0] <= vi_y;
    vz[0] <= vi_z;
    vzero[0] <= (t3_hx == '0) && (t3_hy == '0);
    for (int i = 0; i < N_ITER; i++) begin
      vzero[i+1] <= vzero[i];
      if (vy[i] > 0) begin
        vx[i+1] <= vx[i] + (vy[i] >>> i);
        vy[i+1] <= vy[i] - (vx[i] >>> i);
        vz[i+1] <= vz[i] + $signed(VZ_W'(ATAN_TAB[i]));
      end else begin
        vx[i+1] <= vx[i] - (vy[i] >>> i);
        vy[i+1] <= vy[i] + (vx[i] >>> i);
        vz[i+1] <= vz[i] - $signed(VZ_W'(ATAN_TAB[i]));
      end
    end
  end

  // radians to tenths of a degree
  always_comb begin
    hu = U_W'(vz[N_ITER][VZ_W-1] ? -vz[N_ITER] : vz[N_ITER]);
    h_rem = 47'(h2_un) - 47'(h2_qp);
    h_q = (h_rem >= 47'(PI_MAG)) ? h2_qe + 14'd1 : h2_qe;
    h_qs = (h_q > HEAD_MAX) ? HEAD_MAX : h_q;
  end

  always_ff @(posedge clk) begin
    h1_u <= hu;
    h1_prod <= 46'(hu) * HEAD_RECIP;
    h1_sgn <= vz[N_ITER][VZ_W-1];
    h1_zero <= vzero[N_ITER];
    h2_qe <= h1_prod[45:32];
    h2_un <= 45'(h1_u) * HEAD_SCALE;
    h2_qp <= 46'(h1_prod[45:32]) * PI_MAG;
    h2_sgn <= h1_sgn;
    h2_zero <= h1_zero;
    if (h2_zero) begin
      h3_head <= '0;
    end else begin
      h3_head <= h2_sgn ? -12'(h_qs) : 12'(h_qs);
    end
  end

  assign done = vld[LATENCY-1];
  assign rsp.heading_tenths = h3_head;
  assign rsp.field_x_milli = mil[AXIS_X][MILLI_DLY-1];
  assign rsp.field_y_milli = mil[AXIS_Y][MILLI_DLY-1];
  assign rsp.field_z_milli = mil[AXIS_Z][MILLI_DLY-1];

endmodule

// ----- hw/rtl/tcch_check.sv -----
`timescale 1ns / 1ps
// tcch_check: port-level assertions for the compass heading top level, bound to it
// depends on tcch_pkg and tilt_compensated_compass_heading_top

module tcch_check (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input tcch_pkg::tcch_out_t rsp,
  input logic                pready
);
  import tcch_pkg::*;

  // every accepted request is followed by done
  a_req_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("request produced no result at the pipeline latency");

  // no result without a request
  a_done_has_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching request");

  // heading stays in range
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ($signed(rsp.heading_tenths) <= 12'sd1800 &&
              $signed(rsp.heading_tenths) >= -12'sd1800))
    else $error("heading out of range");

  // apb never waits
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind tilt_compensated_compass_heading_top tcch_check u_tcch_check (.*);
